>>> hdl/rtcb_pkg.sv
// Shared types and constants for the range toggle / count light row.
`timescale 1ns / 1ps
`default_nettype none

package rtcb_pkg;

	localparam int WORD_W         = 32;
	localparam int BIT_W          = $clog2(WORD_W);
	localparam int POS_W          = 11;
	localparam int WIDX_W         = POS_W - BIT_W;
	localparam int POS_MAX        = (1 << POS_W) - 1;
	localparam int MAX_LIGHTS_DEF = 1024;
	localparam logic [POS_W-1:0] LIGHT_COUNT_RST = POS_W'(1024);

	localparam logic REQ_TOGGLE = 1'b0;
	localparam logic REQ_COUNT  = 1'b1;

	// Operation held steady while the token runs down the chain.
	// lo0/hi0 are zero-based and clipped; apply is low for an empty range.
	typedef struct packed {
		logic             is_count;
		logic             apply;
		logic [POS_W-1:0] lo0;
		logic [POS_W-1:0] hi0;
	} op_t;

	// What one cell hands its neighbor.
	typedef struct packed {
		logic             tok;
		logic [POS_W-1:0] sum;
	} link_t;

endpackage

`default_nettype wire

>>> hdl/rtcb_cell.sv
// One cell of the chain: holds one 32-bit word of light bits.
`timescale 1ns / 1ps
`default_nettype none

module rtcb_cell #(
	parameter int IDX = 0
) (
	input  wire              clk,
	input  wire              arst_n,
	input  rtcb_pkg::op_t    op,
	input  rtcb_pkg::link_t  link_in,
	output rtcb_pkg::link_t  link_out
);
	import rtcb_pkg::*;

	// Cells past what an 11-bit position can reach are never touched.
	localparam bit REACH = (IDX <= ((1 << WIDX_W) - 1));
	localparam logic [WIDX_W-1:0] WI = WIDX_W'(IDX);

	logic [WORD_W-1:0] word_q;
	logic              tok_q;
	logic [POS_W-1:0]  sum_q;

	logic [WIDX_W-1:0] lo_w, hi_w;
	logic [WORD_W-1:0] ones, lo_m, hi_m, mask, hit;
	logic [BIT_W:0]    cnt;

	assign ones = '1;
	assign lo_w = op.lo0[POS_W-1:BIT_W];
	assign hi_w = op.hi0[POS_W-1:BIT_W];

	always_comb begin
		if (lo_w == WI) begin
			lo_m = ones << op.lo0[BIT_W-1:0];
		end else if (lo_w < WI) begin
			lo_m = ones;
		end else begin
			lo_m = '0;
		end
		if (hi_w == WI) begin
			hi_m = ones >> (BIT_W'(WORD_W - 1) - op.hi0[BIT_W-1:0]);
		end else if (hi_w > WI) begin
			hi_m = ones;
		end else begin
			hi_m = '0;
		end
		mask = (REACH && op.apply) ? (lo_m & hi_m) : '0;
	end

	assign hit = word_q & mask;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < WORD_W; i++) begin
			cnt = cnt + {{BIT_W{1'b0}}, hit[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '1;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= link_in.tok;
			if (link_in.tok && op.is_count == REQ_TOGGLE) begin
				word_q <= word_q ^ mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.tok) begin
			sum_q <= POS_W'(link_in.sum + {{(POS_W-BIT_W-1){1'b0}}, cnt});
		end
	end

	assign link_out = '{tok: tok_q, sum: sum_q};

endmodule

`default_nettype wire

>>> hdl/range_toggle_count_bits.sv
// Top level: row of light bits with range toggle and range count.
//
// Usage:
//   Request channel: drive req_type, range_lo, range_hi and raise start;
//   the request is taken at a clock edge where start is high and busy low.
//   req_type 0 inverts lights range_lo..range_hi (1-based, inclusive) and
//   gives no result; req_type 1 returns how many lights in that range are lit.
//   Result: on_count is shown for one cycle with on_count_valid high; the
//   receiver cannot stall it.
//   Config: cfg_data is taken as the light count when cfg_valid and
//   cfg_ready are both high. Write it only while busy is low.
// Timing:
//   A token walks the row of cells, one 32-bit word per cycle. An accept
//   loads the token into launch_q, each cell passes it on through its own
//   register, and the count strobe rises as it leaves the last cell. busy
//   falls at the edge that takes the word; a new request waits for that.
// Reset:
//   arst_n sets every light on, the light count to 1024, and leaves the
//   block idle.
`timescale 1ns / 1ps
`default_nettype none

module range_toggle_count_bits #(
	parameter int MAX_LIGHTS = rtcb_pkg::MAX_LIGHTS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire                       req_type,
	input  wire [rtcb_pkg::POS_W-1:0] range_lo,
	input  wire [rtcb_pkg::POS_W-1:0] range_hi,
	output logic                      on_count_valid,
	output logic [rtcb_pkg::POS_W-1:0] on_count,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire [rtcb_pkg::POS_W-1:0] cfg_data
);
	import rtcb_pkg::*;

	localparam int WORD_COUNT = (MAX_LIGHTS + WORD_W - 1) / WORD_W;
	localparam logic [POS_W-1:0] N_CAP =
		POS_W'((MAX_LIGHTS < POS_MAX) ? MAX_LIGHTS : POS_MAX);

	logic [POS_W-1:0] light_count_q;
	logic             busy_q;
	logic             launch_q;
	op_t              op_q;

	logic [POS_W-1:0] n_use, lo_c, hi_c;
	logic             empty;
	logic             accept;

	link_t            chain [0:WORD_COUNT];
	logic [WORD_COUNT-1:0] tok_vec;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;

	// Clip the range to the lights in use.
	always_comb begin
		n_use = (light_count_q > N_CAP) ? N_CAP : light_count_q;
		lo_c  = (range_lo == '0) ? POS_W'(1) : range_lo;
		hi_c  = (range_hi > n_use) ? n_use : range_hi;
		empty = (n_use == '0) || (lo_c > hi_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_count_q <= LIGHT_COUNT_RST;
			busy_q        <= 1'b0;
			launch_q      <= 1'b0;
		end else begin
			launch_q <= accept;
			if (cfg_valid && cfg_ready) begin
				light_count_q <= cfg_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (chain[WORD_COUNT].tok) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.is_count <= req_type;
			op_q.apply    <= !empty;
			op_q.lo0      <= lo_c - POS_W'(1);
			op_q.hi0      <= hi_c - POS_W'(1);
		end
	end

	assign chain[0] = '{tok: launch_q, sum: '0};

	for (genvar g = 0; g < WORD_COUNT; g++) begin : g_cell
		rtcb_cell #(
			.IDX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op_q),
			.link_in (chain[g]),
			.link_out(chain[g+1])
		);
		assign tok_vec[g] = chain[g+1].tok;
	end

	assign on_count_valid = chain[WORD_COUNT].tok && (op_q.is_count == REQ_COUNT);
	assign on_count       = chain[WORD_COUNT].sum;

	// A result only comes out of a request still in flight.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		on_count_valid |-> busy_q)
		else $error("result strobe while idle");

	// Only one token in the cell row at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_vec, launch_q}))
		else $error("more than one token in chain");

	// An accepted request launches a token into the first cell.
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (launch_q && busy_q))
		else $error("accepted request not launched");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the light row: range toggle and range count against a bit-level predictor.
`timescale 1ns / 1ps

module tb_top;
	import rtcb_pkg::*;

	localparam int SETTLE         = 40;   // one full token pass plus margin
	localparam int WATCH_LIMIT    = 4000;
	localparam int RAND_PER_PHASE = 56;
	localparam int PHASES         = 8;
	localparam int DIR_ROWS       = 25;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		logic             typed;
		logic [POS_W-1:0] want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             req_type;
	logic [POS_W-1:0] range_lo;
	logic [POS_W-1:0] range_hi;
	logic             on_count_valid;
	logic [POS_W-1:0] on_count;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [POS_W-1:0] cfg_data;

	// predictor state
	bit [MAX_LIGHTS_DEF-1:0] light_row;
	logic [POS_W-1:0]        light_count_reg;
	logic [POS_W-1:0]        count_due[$];
	logic [POS_W-1:0]        count_head;
	int                      err_cnt;
	int                      idle_cycles;

	range_toggle_count_bits u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.range_lo       (range_lo),
		.range_hi       (range_hi),
		.on_count_valid (on_count_valid),
		.on_count       (on_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one request to the predicted row; returns the lit count in range for a count, zero for a toggle.
	function automatic logic [POS_W-1:0] run_light_request(logic kind, logic [POS_W-1:0] lo,
			logic [POS_W-1:0] hi);
		int n;
		int a;
		int b;
		int total;
		n = (light_count_reg > MAX_LIGHTS_DEF) ? MAX_LIGHTS_DEF : int'(light_count_reg);
		a = (lo < 1) ? 1 : int'(lo);
		b = (int'(hi) > n) ? n : int'(hi);
		total = 0;
		if (n != 0 && a <= b) begin
			for (int p = a - 1; p < b; p++) begin
				if (kind == REQ_COUNT)
					total += light_row[p];
				else
					light_row[p] = ~light_row[p];
			end
		end
		return total[POS_W-1:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Entered at a falling edge; leaves at the falling edge after the accept.
	task automatic send_request(input logic kind, input logic [POS_W-1:0] lo,
			input logic [POS_W-1:0] hi, input logic typed, input logic [POS_W-1:0] want);
		logic [POS_W-1:0] got;
		req_type <= kind;
		range_lo <= lo;
		range_hi <= hi;
		start    <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		got = run_light_request(kind, lo, hi);
		if (kind == REQ_COUNT)
			count_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic idle_gap(input bit no_idle);
		int g;
		g = no_idle ? 0 : pick_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// Toggles give no word back, so wait out a full pass after the queue drains.
	task automatic drain_and_settle();
		start <= 1'b0;
		while (count_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic write_light_count(input logic [POS_W-1:0] val);
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		light_count_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_range(output logic [POS_W-1:0] lo, output logic [POS_W-1:0] hi);
		int n;
		int a;
		int b;
		int r;
		n = (light_count_reg > MAX_LIGHTS_DEF) ? MAX_LIGHTS_DEF : int'(light_count_reg);
		if (n == 0)
			n = MAX_LIGHTS_DEF;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			a = $urandom_range(1, n);
			b = $urandom_range(a, n);
		end else if (r < 70) begin
			// short span, often straddling a word edge
			a = $urandom_range(1, n);
			b = a + $urandom_range(0, 40);
			if (b > n)
				b = n;
		end else if (r < 85) begin
			a = $urandom_range(0, POS_MAX);
			b = $urandom_range(0, POS_MAX);
		end else begin
			// reversed
			b = $urandom_range(0, n);
			a = b + $urandom_range(1, 8);
		end
		lo = a[POS_W-1:0];
		hi = b[POS_W-1:0];
	endtask

	always @(posedge clk) begin
		if (arst_n && on_count_valid) begin
			if (count_due.size() == 0) begin
				$error("on_count: unexpected word, expected none, got %0d", on_count);
				err_cnt++;
			end else begin
				count_head = count_due.pop_front();
				if (on_count !== count_head) begin
					$error("on_count mismatch: expected %0d, got %0d", count_head, on_count);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || on_count_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		dir_row_t         plan [DIR_ROWS];
		logic [POS_W-1:0] phase_cfg [PHASES];
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		logic             kind;
		bit               no_idle;

		clk             = 1'b0;
		arst_n          = 1'b0;
		start           = 1'b0;
		req_type        = REQ_TOGGLE;
		range_lo        = '0;
		range_hi        = '0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		light_row       = '1;
		light_count_reg = LIGHT_COUNT_RST;
		err_cnt         = 0;
		idle_cycles     = 0;

		plan = '{
			'{REQ_COUNT,  11'd1,    11'd1024, 1'b1, 11'd1024},
			'{REQ_COUNT,  11'd0,    11'd2047, 1'b1, 11'd1024},
			'{REQ_COUNT,  11'd5,    11'd4,    1'b1, 11'd0},
			'{REQ_COUNT,  11'd1,    11'd1,    1'b1, 11'd1},
			'{REQ_COUNT,  11'd1024, 11'd1024, 1'b1, 11'd1},
			'{REQ_TOGGLE, 11'd1,    11'd1024, 1'b0, 11'd0},
			'{REQ_COUNT,  11'd1,    11'd1024, 1'b1, 11'd0},
			'{REQ_TOGGLE, 11'd0,    11'd2047, 1'b0, 11'd0},
			'{REQ_COUNT,  11'd1,    11'd1024, 1'b1, 11'd1024},
			'{REQ_TOGGLE, 11'd10,   11'd5,    1'b0, 11'd0},
			'{REQ_COUNT,  11'd1,    11'd1024, 1'b1, 11'd1024},
			'{REQ_TOGGLE, 11'd1,    11'd1,    1'b0, 11'd0},
			'{REQ_COUNT,  11'd1,    11'd32,   1'b1, 11'd31},
			'{REQ_TOGGLE, 11'd32,   11'd33,   1'b0, 11'd0},
			'{REQ_COUNT,  11'd30,   11'd35,   1'b0, 11'd0},
			'{REQ_TOGGLE, 11'd1025, 11'd2047, 1'b0, 11'd0},
			'{REQ_COUNT,  11'd1025, 11'd2047, 1'b1, 11'd0},
			'{REQ_COUNT,  11'd2047, 11'd0,    1'b1, 11'd0},
			'{REQ_TOGGLE, 11'd100,  11'd900,  1'b0, 11'd0},
			'{REQ_COUNT,  11'd1,    11'd1024, 1'b0, 11'd0},
			'{REQ_COUNT,  11'd0,    11'd0,    1'b1, 11'd0},
			'{REQ_TOGGLE, 11'd0,    11'd0,    1'b0, 11'd0},
			'{REQ_COUNT,  11'd1,    11'd1024, 1'b0, 11'd0},
			'{REQ_TOGGLE, 11'd1,    11'd1024, 1'b0, 11'd0},
			'{REQ_COUNT,  11'd1,    11'd1024, 1'b0, 11'd0}
		};
		// zero and over-range counts included; 1024 last to see high lights kept
		phase_cfg = '{11'd1, 11'd0, 11'd2047, 11'd33, 11'd32, 11'd0, 11'd1000, 11'd1024};
		phase_cfg[5] = POS_W'($urandom_range(2, 1023));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_light_count(LIGHT_COUNT_RST);

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_request(plan[i].kind, plan[i].lo, plan[i].hi, plan[i].typed, plan[i].want);
			idle_gap(i < 8);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_and_settle();
			write_light_count(phase_cfg[ph]);
			no_idle = 1'b0;
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (i % 16 == 0)
					no_idle = ($urandom_range(0, 2) == 0);
				kind = ($urandom_range(0, 99) < 45) ? REQ_COUNT : REQ_TOGGLE;
				pick_range(lo, hi);
				send_request(kind, lo, hi, 1'b0, '0);
				idle_gap(no_idle);
			end
		end

		drain_and_settle();
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
hdl/rtcb_pkg.sv
hdl/rtcb_cell.sv
hdl/range_toggle_count_bits.sv
bench/tb_top.sv
